// ----- rtl/pgap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgap_pkg
// Shared types and constants of the 2x2x2 particle grid averaging block.
// ----------------------------------------------------------------------------
package pgap_pkg;

    localparam int DATA_W   = 32;
    localparam int NUM_COMP = 6;
    localparam int CFG_W    = 5;
    localparam int SUM_W    = DATA_W + 3;
    localparam int WORD_W   = DATA_W * NUM_COMP;
    localparam int CELL_N   = 8;
    localparam int CELL_W   = 3;

    // Reset value of the fine side register.
    localparam logic [CFG_W-1:0] FINE_SIDE_RST = 5'd16;

    typedef logic signed [DATA_W-1:0] t_comp;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

endpackage

// ----- rtl/pgap_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgap_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pgap_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/particle_grid_avg_pool_2x2x2_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_grid_avg_pool_2x2x2_top
// Loads a cubic grid of particles and emits 2x2x2 averaged coarse particles.
// ----------------------------------------------------------------------------
// A load request (mode 0) is taken while busy is low and writes one fine particle
// into the particle memory; loads beyond S^3 are dropped. Once the grid is
// full, each emit request (mode 1) reads the eight fine particles of the next
// coarse cell from the single read port of that memory, one per cycle, and the
// averaged particle appears on the outputs with o_valid high for one cycle,
// both registered at the end of the drain state. busy stays high through the
// eight reads and the drain, and the block takes no new request until it
// falls, so each emit is finished before the next is taken. The outputs are not held:
// the receiver must take each result in the cycle it is shown. Emit requests
// before the grid is full are dropped. Writing fine_side restarts the grid.
// ----------------------------------------------------------------------------
module particle_grid_avg_pool_2x2x2_top
    import pgap_pkg::*;
#(
    parameter int MAX_FINE_SIDE = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_mode,
    input  logic signed [DATA_W-1:0] i_pos_x,
    input  logic signed [DATA_W-1:0] i_pos_y,
    input  logic signed [DATA_W-1:0] i_pos_z,
    input  logic signed [DATA_W-1:0] i_vel_x,
    input  logic signed [DATA_W-1:0] i_vel_y,
    input  logic signed [DATA_W-1:0] i_vel_z,
    // result channel
    output logic                    o_valid,
    output logic signed [DATA_W-1:0] o_avg_pos_x,
    output logic signed [DATA_W-1:0] o_avg_pos_y,
    output logic signed [DATA_W-1:0] o_avg_pos_z,
    output logic signed [DATA_W-1:0] o_avg_vel_x,
    output logic signed [DATA_W-1:0] o_avg_vel_y,
    output logic signed [DATA_W-1:0] o_avg_vel_z,
    output logic                    o_last_cell,
    // configuration channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int DEPTH = MAX_FINE_SIDE * MAX_FINE_SIDE * MAX_FINE_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int LCW   = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_FINE_SIDE + 1);
    localparam int SQW   = $clog2(MAX_FINE_SIDE * MAX_FINE_SIDE + 1);
    localparam int CCW   = SW - 1;
    localparam int CMPW  = (SW > CFG_W) ? SW : CFG_W;
    localparam int RST_SIDE = (FINE_SIDE_RST < 2) ? 2 :
                              (FINE_SIDE_RST > MAX_FINE_SIDE) ? MAX_FINE_SIDE :
                              FINE_SIDE_RST;

    function automatic logic [SW-1:0] f_clamp(input logic [CFG_W-1:0] v);
        logic [CMPW-1:0] ext;
        logic [SW-1:0]   res;
        ext = CMPW'(v);
        if (ext < CMPW'(2)) begin
            res = SW'(2);
        end else if (ext > CMPW'(MAX_FINE_SIDE)) begin
            res = SW'(MAX_FINE_SIDE);
        end else begin
            res = SW'(ext);
        end
        return res;
    endfunction

    t_state           r_state, n_state;
    logic [SW-1:0]    r_side;
    logic [SQW-1:0]   r_side_sq;
    logic [LCW-1:0]   r_total;
    logic [LCW-1:0]   r_load_cnt;
    logic [CCW-1:0]   r_cx, r_cy, r_cz;
    logic [LCW-1:0]   r_bx, r_by, r_bz;
    logic [CELL_W-1:0] r_idx;
    t_sum             r_acc [NUM_COMP];
    t_comp            r_avg [NUM_COMP];
    logic             r_last;
    logic             r_out_vld;

    logic [SW-1:0]    cfg_side;
    logic [SQW-1:0]   cfg_sq;
    logic             cfg_wr;
    logic             accept;
    logic             do_load;
    logic             do_emit;
    logic [CCW-1:0]   c_max;
    logic             is_last;
    logic [LCW-1:0]   rd_off;
    logic [LCW-1:0]   rd_sum;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] rdata;
    t_sum             fin_sum [NUM_COMP];

    assign cfg_side = f_clamp(i_cfg_data);
    assign cfg_sq   = SQW'(SQW'(cfg_side) * SQW'(cfg_side));

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign accept      = start && !busy;
    assign do_load     = accept && !i_mode && (r_load_cnt < r_total);
    assign do_emit     = accept && i_mode && (r_load_cnt == r_total);

    assign c_max   = r_side[SW-1:1] - CCW'(1);
    assign is_last = (r_cx == c_max) && (r_cy == c_max) && (r_cz == c_max);

    // Corner n of the cell sits at base + n[0] + n[1]*S + n[2]*S*S.
    assign rd_off = LCW'(r_idx[0]) +
                    (r_idx[1] ? LCW'(r_side) : '0) +
                    (r_idx[2] ? LCW'(r_side_sq) : '0);
    assign rd_sum = LCW'(r_bx + r_by + r_bz + rd_off);

    assign wdata = {i_vel_z, i_vel_y, i_vel_x, i_pos_z, i_pos_y, i_pos_x};

    pgap_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (r_load_cnt[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (rd_sum[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        for (int f = 0; f < NUM_COMP; f++) begin
            fin_sum[f] = r_acc[f] + SUM_W'(signed'(rdata[f*DATA_W +: DATA_W]));
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (do_emit) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_idx == CELL_W'(CELL_N - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_side     <= SW'(RST_SIDE);
            r_side_sq  <= SQW'(RST_SIDE * RST_SIDE);
            r_total    <= LCW'(RST_SIDE * RST_SIDE * RST_SIDE);
            r_load_cnt <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_cz       <= '0;
            r_bx       <= '0;
            r_by       <= '0;
            r_bz       <= '0;
            r_idx      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= (r_state == ST_DRAIN);

            if (r_state == ST_READ) begin
                r_idx <= r_idx + CELL_W'(1);
            end else begin
                r_idx <= '0;
            end

            if (cfg_wr) begin
                r_side     <= cfg_side;
                r_side_sq  <= cfg_sq;
                r_total    <= LCW'(LCW'(cfg_sq) * LCW'(cfg_side));
                r_load_cnt <= '0;
                r_cx       <= '0;
                r_cy       <= '0;
                r_cz       <= '0;
                r_bx       <= '0;
                r_by       <= '0;
                r_bz       <= '0;
            end else if (do_load) begin
                r_load_cnt <= r_load_cnt + LCW'(1);
            end else if (r_state == ST_DRAIN) begin
                // Step to the next cell, z fastest; the base address follows.
                if (is_last) begin
                    r_load_cnt <= '0;
                    r_cx <= '0;
                    r_cy <= '0;
                    r_cz <= '0;
                    r_bx <= '0;
                    r_by <= '0;
                    r_bz <= '0;
                end else if (r_cz != c_max) begin
                    r_cz <= r_cz + CCW'(1);
                    r_bz <= r_bz + LCW'({r_side_sq, 1'b0});
                end else if (r_cy != c_max) begin
                    r_cz <= '0;
                    r_bz <= '0;
                    r_cy <= r_cy + CCW'(1);
                    r_by <= r_by + LCW'({r_side, 1'b0});
                end else begin
                    r_cz <= '0;
                    r_bz <= '0;
                    r_cy <= '0;
                    r_by <= '0;
                    r_cx <= r_cx + CCW'(1);
                    r_bx <= r_bx + LCW'(2);
                end
            end
        end
    end

    // Read data of corner n arrives while r_idx is n + 1; the last corner
    // arrives in the drain cycle and goes straight into the result.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ && r_idx != '0) begin
            for (int f = 0; f < NUM_COMP; f++) begin
                if (r_idx == CELL_W'(1)) begin
                    r_acc[f] <= SUM_W'(signed'(rdata[f*DATA_W +: DATA_W]));
                end else begin
                    r_acc[f] <= fin_sum[f];
                end
            end
        end
        if (r_state == ST_DRAIN) begin
            for (int f = 0; f < NUM_COMP; f++) begin
                r_avg[f] <= fin_sum[f][SUM_W-1:3];
            end
            r_last <= is_last;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_avg_pos_x = r_avg[0];
    assign o_avg_pos_y = r_avg[1];
    assign o_avg_pos_z = r_avg[2];
    assign o_avg_vel_x = r_avg[3];
    assign o_avg_vel_y = r_avg[4];
    assign o_avg_vel_z = r_avg[5];
    assign o_last_cell = r_last;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2x2 particle grid averaging block. It loads
// fine grids of several sides, requests the coarse cells, and compares every
// averaged particle with a behavioral predictor kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
    import pgap_pkg::*;

    localparam int MAX_SIDE     = 16;
    localparam int STORE_DEPTH  = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int IDLE_PCT     = 36;
    localparam int DRAIN_CYCLES = 14;
    localparam int RANDOM_GOAL  = 800;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    localparam logic [DATA_W-1:0] COMP_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] COMP_MIN = 32'h8000_0000;

    typedef logic [NUM_COMP-1:0][DATA_W-1:0] comp_vec_t;

    typedef struct packed {
        comp_vec_t comp;
        logic      last;
    } coarse_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_MAX,
        FILL_MIN,
        FILL_NEAR_ZERO,
        FILL_CORNERS
    } fill_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_mode;
    logic signed [DATA_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [DATA_W-1:0] i_vel_x, i_vel_y, i_vel_z;
    logic o_valid;
    logic signed [DATA_W-1:0] o_avg_pos_x, o_avg_pos_y, o_avg_pos_z;
    logic signed [DATA_W-1:0] o_avg_vel_x, o_avg_vel_y, o_avg_vel_z;
    logic o_last_cell;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    // Predictor state: a copy of the fine particle memory and both counters.
    comp_vec_t        fine_mem [STORE_DEPTH];
    logic [CFG_W-1:0] side_reg = FINE_SIDE_RST;
    int unsigned      loaded_cnt = 0;
    int unsigned      emitted_cnt = 0;

    coarse_t     pending_cells [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned useful_count = 0;
    bit          idle_on = 1'b1;

    string comp_names [NUM_COMP] = '{"avg_pos_x", "avg_pos_y", "avg_pos_z",
                                     "avg_vel_x", "avg_vel_y", "avg_vel_z"};

    particle_grid_avg_pool_2x2x2_top #(
        .MAX_FINE_SIDE(MAX_SIDE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_vel_z     (i_vel_z),
        .o_valid     (o_valid),
        .o_avg_pos_x (o_avg_pos_x),
        .o_avg_pos_y (o_avg_pos_y),
        .o_avg_pos_z (o_avg_pos_z),
        .o_avg_vel_x (o_avg_vel_x),
        .o_avg_vel_y (o_avg_vel_y),
        .o_avg_vel_z (o_avg_vel_z),
        .o_last_cell (o_last_cell),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic int unsigned side_of(input logic [CFG_W-1:0] v);
        int unsigned s;
        s = 32'(v);
        if (s < 2) s = 2;
        if (s > MAX_SIDE) s = MAX_SIDE;
        return s;
    endfunction

    // Applies one accepted request to the predictor. Returns 1 when the
    // request produces a coarse particle; counted marks requests that did work.
    function automatic bit average_cell(input logic mode, input comp_vec_t vals,
                                        output coarse_t res, output bit counted);
        int unsigned s, total, c, cz, cy, cx, base;
        int unsigned offs [CELL_N];
        t_sum acc;
        s = side_of(side_reg);
        total = s * s * s;
        c = s / 2;
        res = '0;
        counted = 1'b0;
        if (mode == MODE_LOAD) begin
            if (loaded_cnt >= total) return 1'b0;
            fine_mem[loaded_cnt] = vals;
            loaded_cnt++;
            counted = 1'b1;
            return 1'b0;
        end
        if (loaded_cnt < total) return 1'b0;
        counted = 1'b1;
        cz = emitted_cnt % c;
        cy = (emitted_cnt / c) % c;
        cx = emitted_cnt / (c * c);
        base = 2 * cx + 2 * s * cy + 2 * s * s * cz;
        offs = '{0, 1, s, s + 1, s * s, s * s + 1, s * s + s, s * s + s + 1};
        for (int f = 0; f < NUM_COMP; f++) begin
            acc = '0;
            for (int n = 0; n < CELL_N; n++)
                acc = acc + $signed(fine_mem[base + offs[n]][f]);
            // Taking bits above the low three is the arithmetic shift by three.
            res.comp[f] = acc[SUM_W-1:3];
        end
        if (emitted_cnt + 1 >= c * c * c) begin
            res.last = 1'b1;
            emitted_cnt = 0;
            loaded_cnt = 0;
        end else begin
            emitted_cnt++;
        end
        return 1'b1;
    endfunction

    function automatic logic [DATA_W-1:0] corner_value();
        case ($urandom_range(3))
            0: return COMP_MAX;
            1: return COMP_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic comp_vec_t make_particle(input fill_t fill);
        comp_vec_t v;
        for (int f = 0; f < NUM_COMP; f++) begin
            case (fill)
                FILL_MAX:       v[f] = COMP_MAX;
                FILL_MIN:       v[f] = COMP_MIN;
                FILL_NEAR_ZERO: v[f] = $urandom_range(1) ? '1 : '0;
                FILL_CORNERS:   v[f] = corner_value();
                default:        v[f] = ($urandom_range(4) == 0) ? corner_value()
                                                                : $urandom();
            endcase
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        coarse_t   want;
        comp_vec_t got;
        if (i_rst_n && o_valid) begin
            got = {o_avg_vel_z, o_avg_vel_y, o_avg_vel_x,
                   o_avg_pos_z, o_avg_pos_y, o_avg_pos_x};
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h last %b",
                         $time, got, o_last_cell);
                error_count++;
            end else begin
                want = pending_cells.pop_front();
                for (int f = 0; f < NUM_COMP; f++) begin
                    if (got[f] !== want.comp[f]) begin
                        $display("%0t: %s expected %h actual %h", $time,
                                 comp_names[f], want.comp[f], got[f]);
                        error_count++;
                    end
                end
                if (o_last_cell !== want.last) begin
                    $display("%0t: last_cell expected %b actual %b", $time,
                             want.last, o_last_cell);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input logic mode, input comp_vec_t vals);
        coarse_t res;
        bit      counted;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_mode  <= mode;
        i_pos_x <= vals[0];
        i_pos_y <= vals[1];
        i_pos_z <= vals[2];
        i_vel_x <= vals[3];
        i_vel_y <= vals[4];
        i_vel_z <= vals[5];
        do @(posedge i_clk); while (busy);
        if (average_cell(mode, vals, res, counted)) pending_cells.push_back(res);
        if (counted) useful_count++;
    endtask

    // Holds requests off until every coarse particle has come back and the
    // block has had time to finish anything still in flight.
    task automatic settle();
        start <= 1'b0;
        while (pending_cells.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [CFG_W-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        side_reg    = v;
        loaded_cnt  = 0;
        emitted_cnt = 0;
    endtask

    // Loads n particles; with noise_pct percent odds an emit request is slipped
    // in before a load, which the block must drop while the grid is incomplete.
    task automatic load_particles(input int unsigned n, input fill_t fill,
                                  input int unsigned noise_pct);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_request(MODE_EMIT, make_particle(FILL_RANDOM));
            send_request(MODE_LOAD, make_particle(fill));
        end
    endtask

    // Requests n coarse cells, with surplus loads mixed in as noise.
    task automatic emit_cells(input int unsigned n, input int unsigned noise_pct);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_request(MODE_LOAD, make_particle(FILL_RANDOM));
            send_request(MODE_EMIT, make_particle(FILL_RANDOM));
        end
    endtask

    task automatic full_grid(input fill_t fill, input int unsigned noise_pct);
        int unsigned s;
        s = side_of(side_reg);
        load_particles(s * s * s, fill, noise_pct);
        emit_cells((s / 2) * (s / 2) * (s / 2), noise_pct);
    endtask

    // The side register comes out of reset at sixteen. A grid of side eight
    // would be complete after this many loads, so the emit must still be dropped.
    task automatic test_reset_side();
        send_request(MODE_EMIT, make_particle(FILL_RANDOM));
        load_particles((MAX_SIDE / 2) ** 3, FILL_RANDOM, 0);
        send_request(MODE_EMIT, make_particle(FILL_RANDOM));
        settle();
    endtask

    // Back-to-back smallest grids at the value extremes; each one follows
    // the last cell of the one before without a register write.
    task automatic test_value_extremes();
        write_side(5'd2);
        full_grid(FILL_MAX, 0);
        full_grid(FILL_MIN, 0);
        full_grid(FILL_NEAR_ZERO, 0);
        full_grid(FILL_CORNERS, 0);
    endtask

    task automatic test_side_clamp();
        write_side(5'd0);
        full_grid(FILL_RANDOM, 0);
        write_side(5'd1);
        full_grid(FILL_CORNERS, 0);
        // An out-of-range side acts as the maximum, so this grid stays open.
        write_side(5'd31);
        load_particles(20, FILL_RANDOM, 0);
        send_request(MODE_EMIT, make_particle(FILL_RANDOM));
    endtask

    task automatic test_odd_side();
        write_side(5'd3);
        full_grid(FILL_RANDOM, 0);
        write_side(5'd5);
        full_grid(FILL_RANDOM, 0);
    endtask

    // A register write in the middle of a grid or of its emits starts over.
    task automatic test_rewrite_restart();
        write_side(5'd2);
        load_particles(5, FILL_RANDOM, 0);
        write_side(5'd2);
        full_grid(FILL_MAX, 0);
        write_side(5'd4);
        load_particles(64, FILL_RANDOM, 0);
        emit_cells(3, 0);
        write_side(5'd4);
        full_grid(FILL_RANDOM, 0);
    endtask

    task automatic test_random();
        int unsigned r, v, s, total, cells, grids;
        fill_t fill;
        useful_count = 0;
        while (useful_count < RANDOM_GOAL) begin
            r = $urandom_range(99);
            if (r < 10)      v = $urandom_range(1);
            else if (r < 70) v = $urandom_range(4, 2);
            else if (r < 85) v = $urandom_range(8, 5);
            else if (r < 93) v = $urandom_range(16, 9);
            else             v = $urandom_range(31, 17);
            idle_on = ($urandom_range(3) != 0);
            write_side(CFG_W'(v));
            s = side_of(CFG_W'(v));
            total = s * s * s;
            cells = (s / 2) * (s / 2) * (s / 2);
            if (s > 8) begin
                // Large sides only see a partial load before the next write.
                load_particles($urandom_range(total / 8), FILL_RANDOM, 5);
                emit_cells($urandom_range(2), 0);
            end else begin
                grids = $urandom_range(3, 1);
                for (int unsigned g = 0; g < grids; g++) begin
                    fill = ($urandom_range(3) == 0) ? fill_t'($urandom_range(4, 1))
                                                    : FILL_RANDOM;
                    if ($urandom_range(9) == 0) begin
                        load_particles($urandom_range(total), fill, 5);
                        emit_cells($urandom_range(cells), 5);
                        break;
                    end
                    load_particles(total, fill, 5);
                    if ($urandom_range(6) == 0) settle();
                    emit_cells(cells, 5);
                end
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_mode      <= MODE_LOAD;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pos_z     <= '0;
        i_vel_x     <= '0;
        i_vel_y     <= '0;
        i_vel_z     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_side();
        test_value_extremes();
        test_side_clamp();
        test_odd_side();
        test_rewrite_restart();
        test_random();
        settle();

        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
